@@ design/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, step counts and the controller/datapath interface types shared by
// the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int MOD_BITS  = 31;
  localparam int EXP_BITS  = 63;
  localparam int PROD_BITS = 2 * MOD_BITS;
  localparam int RED_STEPS = PROD_BITS;
  localparam int CNT_BITS  = $clog2(RED_STEPS);
  localparam int REM_BITS  = MOD_BITS + 1;

  typedef struct packed {
    logic load;      // capture input word
    logic mul;       // load product registers, start reduction
    logic pre;       // operand reduction pass, no multiply
    logic step;      // one reduction step on both lanes
    logic commit;    // write reduced values back
    logic out_load;  // capture result word
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic red_last;
  } status_t;

endpackage

@@ design/mexp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer: one exponent bit per pass of multiply, serial reduce, commit.
// Owns both handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mexp_pkg::status_t sts,
  output mexp_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_COMMIT,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   pre_r, pre_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pre_nxt       = pre_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          pre_nxt   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!pre_r && sts.exp_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.mul   = 1'b1;
          cmd.pre   = pre_r;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        cmd.step = 1'b1;
        if (sts.red_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        cmd.pre    = pre_r;
        pre_nxt    = 1'b0;
        state_nxt  = ST_MUL;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pre_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pre_r       <= pre_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/mexp_dp.sv @@
// ----------------------------------------------------------------------------
// mexp_dp
// Operand registers, two 31x31 multipliers and two bit-serial restoring
// reducers (result lane and square lane) working in lock step.
// ----------------------------------------------------------------------------
module mexp_dp (
  input  logic                             clk,
  input  logic [mexp_pkg::MOD_BITS-1:0]    in_base_value,
  input  logic [mexp_pkg::EXP_BITS-1:0]    in_exponent_value,
  input  logic [mexp_pkg::MOD_BITS-1:0]    in_modulus_value,
  output logic [mexp_pkg::MOD_BITS-1:0]    out_power_result,
  input  mexp_pkg::cmd_t                   cmd,
  output mexp_pkg::status_t                sts
);

  logic [mexp_pkg::EXP_BITS-1:0]  exp_r, exp_nxt;
  logic [mexp_pkg::MOD_BITS-1:0]  mod_r, mod_nxt;
  logic [mexp_pkg::MOD_BITS-1:0]  acc_r, acc_nxt;
  logic [mexp_pkg::MOD_BITS-1:0]  sq_r, sq_nxt;
  logic [mexp_pkg::PROD_BITS-1:0] prod_a_r, prod_a_nxt;
  logic [mexp_pkg::PROD_BITS-1:0] prod_s_r, prod_s_nxt;
  logic [mexp_pkg::REM_BITS-1:0]  rem_a_r, rem_a_nxt;
  logic [mexp_pkg::REM_BITS-1:0]  rem_s_r, rem_s_nxt;
  logic [mexp_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [mexp_pkg::MOD_BITS-1:0]  res_r, res_nxt;

  logic [mexp_pkg::PROD_BITS-1:0] mul_a, mul_s;
  logic [mexp_pkg::REM_BITS-1:0]  sh_a, sh_s, mod_ext;

  assign mul_a = {{mexp_pkg::MOD_BITS{1'b0}}, acc_r} * {{mexp_pkg::MOD_BITS{1'b0}}, sq_r};
  assign mul_s = {{mexp_pkg::MOD_BITS{1'b0}}, sq_r}  * {{mexp_pkg::MOD_BITS{1'b0}}, sq_r};

  assign mod_ext = {1'b0, mod_r};
  assign sh_a    = {rem_a_r[mexp_pkg::MOD_BITS-1:0], prod_a_r[mexp_pkg::PROD_BITS-1]};
  assign sh_s    = {rem_s_r[mexp_pkg::MOD_BITS-1:0], prod_s_r[mexp_pkg::PROD_BITS-1]};

  always_comb begin
    exp_nxt    = exp_r;
    mod_nxt    = mod_r;
    acc_nxt    = acc_r;
    sq_nxt     = sq_r;
    prod_a_nxt = prod_a_r;
    prod_s_nxt = prod_s_r;
    rem_a_nxt  = rem_a_r;
    rem_s_nxt  = rem_s_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    if (cmd.load) begin
      exp_nxt = in_exponent_value;
      mod_nxt = in_modulus_value;
      sq_nxt  = in_base_value;
      acc_nxt = (in_modulus_value > mexp_pkg::MOD_BITS'(1)) ?
                mexp_pkg::MOD_BITS'(1) : '0;
    end
    if (cmd.mul) begin
      if (cmd.pre) begin
        prod_a_nxt = {{mexp_pkg::MOD_BITS{1'b0}}, acc_r};
        prod_s_nxt = {{mexp_pkg::MOD_BITS{1'b0}}, sq_r};
      end else begin
        prod_a_nxt = mul_a;
        prod_s_nxt = mul_s;
      end
      rem_a_nxt = '0;
      rem_s_nxt = '0;
      cnt_nxt   = '0;
    end
    if (cmd.step) begin
      rem_a_nxt  = (sh_a >= mod_ext) ? sh_a - mod_ext : sh_a;
      rem_s_nxt  = (sh_s >= mod_ext) ? sh_s - mod_ext : sh_s;
      prod_a_nxt = {prod_a_r[mexp_pkg::PROD_BITS-2:0], 1'b0};
      prod_s_nxt = {prod_s_r[mexp_pkg::PROD_BITS-2:0], 1'b0};
      cnt_nxt    = cnt_r + mexp_pkg::CNT_BITS'(1);
    end
    if (cmd.commit) begin
      sq_nxt = rem_s_r[mexp_pkg::MOD_BITS-1:0];
      if (cmd.pre || exp_r[0]) begin
        acc_nxt = rem_a_r[mexp_pkg::MOD_BITS-1:0];
      end
      if (!cmd.pre) begin
        exp_nxt = {1'b0, exp_r[mexp_pkg::EXP_BITS-1:1]};
      end
    end
    if (cmd.out_load) begin
      res_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    exp_r    <= exp_nxt;
    mod_r    <= mod_nxt;
    acc_r    <= acc_nxt;
    sq_r     <= sq_nxt;
    prod_a_r <= prod_a_nxt;
    prod_s_r <= prod_s_nxt;
    rem_a_r  <= rem_a_nxt;
    rem_s_r  <= rem_s_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  assign sts.exp_zero   = (exp_r == '0);
  assign sts.red_last   = (cnt_r == mexp_pkg::CNT_BITS'(mexp_pkg::RED_STEPS - 1));
  assign out_power_result = res_r;

endmodule

@@ design/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus, right-to-left square-and-multiply.
//
//   channel | ports                                           | dir
//   in      | in_valid, in_stall, in_base/exponent/modulus_*  | word in
//   out     | out_valid, out_stall, out_power_result          | word out
//
// Per word: an operand reduction pass, then a multiply, reduce and commit
// pass for each exponent bit up to the highest set bit, each reduce done by
// the 62-step serial reducers; a zero exponent needs only the first pass.
// One word in flight; the next is taken while a result waits at the output.
// Synchronous active-low reset clears the controller only.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mexp_pkg::MOD_BITS-1:0] in_base_value,
  input  logic [mexp_pkg::EXP_BITS-1:0] in_exponent_value,
  input  logic [mexp_pkg::MOD_BITS-1:0] in_modulus_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mexp_pkg::MOD_BITS-1:0] out_power_result
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t sts;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_dp u_dp (
    .clk               (clk),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .in_modulus_value  (in_modulus_value),
    .out_power_result  (out_power_result),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

@@ design/mexp_chk.sv @@
// ----------------------------------------------------------------------------
// mexp_chk
// Port-level checks for modular_exponentiation, bound to the top level.
// ----------------------------------------------------------------------------
module mexp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [mexp_pkg::MOD_BITS-1:0] in_base_value,
  input logic [mexp_pkg::EXP_BITS-1:0] in_exponent_value,
  input logic [mexp_pkg::MOD_BITS-1:0] in_modulus_value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mexp_pkg::MOD_BITS-1:0] out_power_result
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid &&
      $stable({in_base_value, in_exponent_value, in_modulus_value}))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_result))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a word");

  a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (.*);

@@ tb/mexp_checker.sv @@
// ----------------------------------------------------------------------------
// mexp_checker
// Watches both channels of modular_exponentiation, works out the power for
// each accepted input word by square-and-multiply on 64-bit products, and
// compares each result word in order against the oldest outstanding power.
// ----------------------------------------------------------------------------
module mexp_checker
  import mexp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [MOD_BITS-1:0] in_base_value,
  input  logic [EXP_BITS-1:0] in_exponent_value,
  input  logic [MOD_BITS-1:0] in_modulus_value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [MOD_BITS-1:0] out_power_result,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [MOD_BITS-1:0] powers_due[$];

  function automatic logic [MOD_BITS-1:0] power_mod(input logic [MOD_BITS-1:0] b,
                                                    input logic [EXP_BITS-1:0] e,
                                                    input logic [MOD_BITS-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mm;
    if (m == '0) begin
      return '0;
    end
    mm  = 64'(m);
    acc = 64'd1 % mm;
    sq  = 64'(b) % mm;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (e[i]) begin
        acc = (acc * sq) % mm;
      end
      sq = (sq * sq) % mm;
    end
    return acc[MOD_BITS-1:0];
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin
    logic [MOD_BITS-1:0] due;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (powers_due.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: result word %0d with nothing outstanding", $time,
                     out_power_result);
          end
          fail_count++;
        end else begin
          due = powers_due.pop_front();
          checked++;
          if (out_power_result !== due) begin
            if (fail_count < 10) begin
              $display("%0t: power_result mismatch: expected %0d, got %0d", $time,
                       due, out_power_result);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        powers_due.push_back(power_mod(in_base_value, in_exponent_value,
                                       in_modulus_value));
      end
      pending <= powers_due.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for modular_exponentiation: directed corner words (zero and full
// exponents, modulus of one, bases at or above the modulus), then random
// words with mostly short exponents, under random input gaps and output
// stalls. Checking is done by mexp_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mexp_pkg::*;

  localparam logic [MOD_BITS-1:0] MOD_MAX = '1;
  localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MOD_BITS-1:0] in_base_value = '0;
  logic [EXP_BITS-1:0] in_exponent_value = '0;
  logic [MOD_BITS-1:0] in_modulus_value = MOD_BITS'(1);
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MOD_BITS-1:0] out_power_result;

  int fail_count;
  int pending;
  int checked;
  int words_sent = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modular_exponentiation u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .in_modulus_value  (in_modulus_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_power_result  (out_power_result)
  );

  mexp_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .in_modulus_value  (in_modulus_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_power_result  (out_power_result),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(15);
  endfunction

  // called at a rising edge; leaves valid high so back-to-back words need no drop
  task automatic send_word(input logic [MOD_BITS-1:0] b, input logic [EXP_BITS-1:0] e,
                           input logic [MOD_BITS-1:0] m);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_base_value     <= b;
    in_exponent_value <= e;
    in_modulus_value  <= m;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_random_word();
    logic [MOD_BITS-1:0] b;
    logic [EXP_BITS-1:0] e;
    logic [EXP_BITS-1:0] e_mask;
    logic [MOD_BITS-1:0] m;
    int nbits;
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      m = MOD_BITS'($urandom_range(1, 16));
    end else begin
      m = MOD_BITS'($urandom_range(1, 32'h7FFF_FFFF));
    end
    pick = $urandom_range(7);
    if (pick == 0) begin
      b = '0;
    end else if (pick == 1) begin
      b = m;
    end else begin
      b = MOD_BITS'($urandom);
    end
    // short exponents keep the run quick; a few still reach full width
    pick = $urandom_range(9);
    nbits = (pick == 0) ? EXP_BITS : $urandom_range(0, 40);
    e_mask = (EXP_BITS'(1) << nbits) - EXP_BITS'(1);
    e = EXP_BITS'({$urandom, $urandom}) & e_mask;
    send_word(b, e, m);
  endtask

  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      n = draw_wait();
      if (n == 0) begin
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end else begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (n - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word('0, '0, MOD_MAX);
    send_word('0, EXP_BITS'(5), MOD_BITS'(7));
    send_word(MOD_MAX, EXP_MAX, MOD_MAX);
    send_word(MOD_MAX, EXP_MAX, MOD_MAX - MOD_BITS'(1));
    send_word(MOD_BITS'(3), '0, MOD_BITS'(1));
    send_word(MOD_MAX, EXP_MAX, MOD_BITS'(1));
    send_word(MOD_MAX, '0, MOD_BITS'(2));
    send_word(MOD_BITS'(2), EXP_BITS'(10), MOD_BITS'(1000));
    send_word(MOD_BITS'(1000), EXP_BITS'(3), MOD_BITS'(7));
    send_word(MOD_BITS'(7), EXP_BITS'(3), MOD_BITS'(7));
    send_word(MOD_BITS'(2), EXP_BITS'(1) << (EXP_BITS - 1), MOD_MAX);
    send_word(MOD_MAX - MOD_BITS'(2), EXP_BITS'(1), MOD_BITS'(2));
    send_word(MOD_BITS'(123456789), EXP_MAX, MOD_BITS'(1_000_000_007));
    send_word(MOD_BITS'(2), EXP_MAX - EXP_BITS'(1), MOD_MAX);
    send_word(MOD_BITS'(5), EXP_BITS'(1), MOD_MAX);
    send_word(31'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 31'h2AAA_AAAB);
    send_word(31'h2AAA_AAAA, 63'h5555_5555_5555_5555, 31'h5555_5555);
    send_word(MOD_MAX, EXP_BITS'(2), MOD_BITS'(65536));
    send_word(MOD_BITS'(1), EXP_MAX, MOD_BITS'(3));

    // alternate blocks of noisy and back-to-back traffic
    for (int blk = 0; blk < 6; blk++) begin
      calm = blk[0];
      repeat (20) send_random_word();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d words (directed corners and random exponents up to full width),",
             words_sent);
    $display("checked %0d results under random gaps and stalls.", checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
